// ----- rtl/rfd_pkg.sv -----
// Shared types and constants for the record field deframer.
package rfd_pkg;

   localparam int unsigned MAX_SLOTS = 8;
   localparam int unsigned SLOT_W = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
   localparam int unsigned COUNT_W = 4;
   localparam int unsigned WIDTHS_W = 16;
   localparam int unsigned CSR_DATA_W = 16;
   localparam int unsigned CSR_INDEX_W = 2;
   localparam logic [63:0] DROP_MARKER = 64'h0000_0000_FFFF_FFFF;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_FIELD_COUNT  = 2'd0,
      CSR_FIELD_WIDTHS = 2'd1,
      CSR_CHECK_ENABLE = 2'd2
   } csr_index_type;

   typedef enum logic [1:0] {
      WIDTH_2B    = 2'd0,
      WIDTH_4B    = 2'd1,
      WIDTH_8B    = 2'd2,
      WIDTH_FLOAT = 2'd3
   } width_code_type;

endpackage

// ----- rtl/record_field_deframer_core.sv -----
// Top level of the record field deframer: byte stream to little-endian record fields.
//
// Bytes enter on the req_ channel, one per transaction. Each record has a
// configured number of field slots (csr index 0), each 2, 4 or 8 bytes wide
// (csr index 1, two bits per slot) and an optional sequence check on the
// last slot (csr index 2). Completed fields leave on the rsp_ channel with
// their slot number; a field equal to 0xFFFFFFFF is dropped and its slot
// restarts. The last slot of a record sets rsp_record_done and, with the
// check enabled, rsp_sequence_error on a mismatch with a counter that starts
// at 1 and advances once per checked record.
// Throughput is one byte per cycle unless the receiver stalls. A byte that completes
// a field gives its transaction on rsp_ in the cycle after acceptance; the field
// logic and the result register form a single stage.
// Reset (synchronous, active high) clears the field state, the counter (to 1)
// and the registers (count 1, widths 0, check off).
// When the receiver stalls with a result held, the result register holds and
// req_ready stays low until that result is taken. csr_ is always ready.
module record_field_deframer_core (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic [7:0]                        req_data_byte,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic [rfd_pkg::SLOT_W-1:0]        rsp_slot_number,
   output logic [63:0]                       rsp_field_value,
   output logic                              rsp_record_done,
   output logic                              rsp_sequence_error,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [rfd_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [rfd_pkg::CSR_DATA_W-1:0]    csr_data
);

   logic [rfd_pkg::COUNT_W-1:0]  field_count_ff;
   logic [rfd_pkg::WIDTHS_W-1:0] field_widths_ff;
   logic                         check_enable_ff;

   logic [63:0]                  acc_ff, acc_in;
   logic [2:0]                   bytes_ff, bytes_in;
   logic [rfd_pkg::SLOT_W-1:0]   slot_ff, slot_in;
   logic [63:0]                  expected_ff, expected_in;

   logic                         rsp_valid_ff;
   logic [rfd_pkg::SLOT_W-1:0]   rsp_slot_ff;
   logic [63:0]                  rsp_value_ff;
   logic                         rsp_done_ff;
   logic                         rsp_err_ff;

   logic                         req_accept;
   logic                         rsp_load;
   rfd_pkg::width_code_type      width_code;
   logic [3:0]                   width_bytes;
   logic [63:0]                  width_mask;
   logic [63:0]                  acc_merged;
   logic [63:0]                  value;
   logic                         complete;
   logic                         drop;
   logic [rfd_pkg::COUNT_W-1:0]  eff_count;
   logic                         done;
   logic                         err;

   assign req_ready  = !rsp_valid_ff || rsp_ready;
   assign req_accept = req_valid && req_ready;
   assign csr_ready  = 1'b1;

   always_comb begin
      width_code = rfd_pkg::width_code_type'(field_widths_ff[{slot_ff, 1'b0} +: 2]);
      case (width_code)
         rfd_pkg::WIDTH_2B: begin
            width_bytes = 4'd2;
            width_mask  = 64'h0000_0000_0000_FFFF;
         end
         rfd_pkg::WIDTH_8B: begin
            width_bytes = 4'd8;
            width_mask  = '1;
         end
         default: begin
            width_bytes = 4'd4;
            width_mask  = 64'h0000_0000_FFFF_FFFF;
         end
      endcase

      if (field_count_ff == '0) begin
         eff_count = rfd_pkg::COUNT_W'(1);
      end else if (field_count_ff > rfd_pkg::COUNT_W'(rfd_pkg::MAX_SLOTS)) begin
         eff_count = rfd_pkg::COUNT_W'(rfd_pkg::MAX_SLOTS);
      end else begin
         eff_count = field_count_ff;
      end

      acc_merged = acc_ff | ({56'd0, req_data_byte} << {bytes_ff, 3'b000});
      value      = acc_merged & width_mask;
      complete   = ({1'b0, bytes_ff} + 4'd1) >= width_bytes;
      drop       = value == rfd_pkg::DROP_MARKER;
      done       = (rfd_pkg::COUNT_W'(slot_ff) + rfd_pkg::COUNT_W'(1)) >= eff_count;
      err        = check_enable_ff && done && (value != expected_ff);
      rsp_load   = req_accept && complete && !drop;

      acc_in      = acc_ff;
      bytes_in    = bytes_ff;
      slot_in     = slot_ff;
      expected_in = expected_ff;
      if (req_accept) begin
         if (complete) begin
            acc_in   = '0;
            bytes_in = '0;
            if (!drop) begin
               slot_in = done ? '0 : slot_ff + rfd_pkg::SLOT_W'(1);
               if (done && check_enable_ff) begin
                  expected_in = expected_ff + 64'd1;
               end
            end
         end else begin
            acc_in   = acc_merged;
            bytes_in = bytes_ff + 3'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         field_count_ff  <= rfd_pkg::COUNT_W'(1);
         field_widths_ff <= '0;
         check_enable_ff <= 1'b0;
         acc_ff          <= '0;
         bytes_ff        <= '0;
         slot_ff         <= '0;
         expected_ff     <= 64'd1;
         rsp_valid_ff    <= 1'b0;
      end else begin
         if (csr_valid && csr_ready) begin
            case (rfd_pkg::csr_index_type'(csr_index))
               rfd_pkg::CSR_FIELD_COUNT:  field_count_ff  <= csr_data[rfd_pkg::COUNT_W-1:0];
               rfd_pkg::CSR_FIELD_WIDTHS: field_widths_ff <= csr_data[rfd_pkg::WIDTHS_W-1:0];
               rfd_pkg::CSR_CHECK_ENABLE: check_enable_ff <= csr_data[0];
               default: ;
            endcase
         end
         acc_ff      <= acc_in;
         bytes_ff    <= bytes_in;
         slot_ff     <= slot_in;
         expected_ff <= expected_in;
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_slot_ff  <= slot_ff;
         rsp_value_ff <= value;
         rsp_done_ff  <= done;
         rsp_err_ff   <= err;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_slot_number    = rsp_slot_ff;
   assign rsp_field_value    = rsp_value_ff;
   assign rsp_record_done    = rsp_done_ff;
   assign rsp_sequence_error = rsp_err_ff;

   a_err_needs_done: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_sequence_error |-> rsp_record_done)
      else $error("sequence error without record end");

   a_slot_wraps: assert property (@(posedge clock) disable iff (reset)
      rsp_load && done |=> slot_ff == '0)
      else $error("slot did not return to zero after record end");

   a_field_clears: assert property (@(posedge clock) disable iff (reset)
      req_accept && complete |=> bytes_ff == '0 && acc_ff == '0)
      else $error("field state not cleared after completion");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_ready |-> !rsp_load)
      else $error("held result overwritten");

endmodule

// ----- dv/record_field_deframer_core_tb.sv -----
// Self-checking testbench for record_field_deframer_core: random byte records against a predictor.
module record_field_deframer_core_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [rfd_pkg::CSR_INDEX_W-1:0] CSR_SPARE_INDEX = 2'd3;
   localparam int unsigned SETTLE_CYCLES = 4;
   localparam int unsigned PHASE_COUNT = 14;
   localparam int unsigned PHASE_BYTES = 135;
   localparam int unsigned CYCLE_LIMIT = 200000;

   typedef struct packed {
      logic [rfd_pkg::SLOT_W-1:0] slot;
      logic [63:0]                value;
      logic                       done;
      logic                       err;
   } field_result_type;

   class deframer_scoreboard_type;
      logic [rfd_pkg::COUNT_W-1:0]  field_count;
      logic [rfd_pkg::WIDTHS_W-1:0] field_widths;
      logic                         check_enable;
      logic [63:0]                  accumulator;
      int unsigned                  collected;
      int unsigned                  slot;
      logic [63:0]                  next_sequence;
      field_result_type             pending_fields[$];
      int unsigned                  mismatches;

      function new();
         field_count = rfd_pkg::COUNT_W'(1);
         field_widths = '0;
         check_enable = 1'b0;
         accumulator = '0;
         collected = 0;
         slot = 0;
         next_sequence = 64'd1;
         mismatches = 0;
      endfunction

      function int unsigned slot_bytes(int unsigned s);
         rfd_pkg::width_code_type code;
         code = rfd_pkg::width_code_type'(field_widths[2*s +: 2]);
         case (code)
            rfd_pkg::WIDTH_2B: return 2;
            rfd_pkg::WIDTH_8B: return 8;
            default:           return 4;
         endcase
      endfunction

      function int unsigned slot_limit();
         int unsigned c;
         c = 32'(field_count);
         if (c == 0) c = 1;
         if (c > rfd_pkg::MAX_SLOTS) c = rfd_pkg::MAX_SLOTS;
         return c;
      endfunction

      function void write_register(logic [rfd_pkg::CSR_INDEX_W-1:0] idx,
                                   logic [rfd_pkg::CSR_DATA_W-1:0] d);
         case (idx)
            rfd_pkg::CSR_FIELD_COUNT:  field_count = d[rfd_pkg::COUNT_W-1:0];
            rfd_pkg::CSR_FIELD_WIDTHS: field_widths = d[rfd_pkg::WIDTHS_W-1:0];
            rfd_pkg::CSR_CHECK_ENABLE: check_enable = d[0];
            default: ;
         endcase
      endfunction

      function void accept_byte(logic [7:0] b);
         int unsigned      w;
         logic [63:0]      v;
         field_result_type r;
         w = slot_bytes(slot);
         accumulator |= 64'(b) << (8 * collected);
         if (collected + 1 < w) begin
            collected++;
            return;
         end
         v = accumulator;
         if (w < 8) v &= (64'd1 << (8 * w)) - 64'd1;
         accumulator = '0;
         collected = 0;
         if (v == rfd_pkg::DROP_MARKER) return;
         r.slot = rfd_pkg::SLOT_W'(slot);
         r.value = v;
         r.done = (slot + 1 >= slot_limit());
         r.err = 1'b0;
         if (r.done) begin
            slot = 0;
            if (check_enable) begin
               r.err = (v != next_sequence);
               next_sequence++;
            end
         end else begin
            slot++;
         end
         pending_fields = {pending_fields, r};
      endfunction

      function void check_field(field_result_type got);
         field_result_type want;
         if (pending_fields.size() == 0) begin
            $display("%0t: expected no transaction, actual slot %0d value %h", $time,
                     got.slot, got.value);
            mismatches++;
            return;
         end
         want = pending_fields.pop_front();
         if (got.slot !== want.slot) begin
            $display("%0t: slot_number expected %0d actual %0d", $time, want.slot, got.slot);
            mismatches++;
         end
         if (got.value !== want.value) begin
            $display("%0t: field_value expected %h actual %h", $time, want.value, got.value);
            mismatches++;
         end
         if (got.done !== want.done) begin
            $display("%0t: record_done expected %b actual %b", $time, want.done, got.done);
            mismatches++;
         end
         if (got.err !== want.err) begin
            $display("%0t: sequence_error expected %b actual %b", $time, want.err, got.err);
            mismatches++;
         end
      endfunction
   endclass

   logic                            clock = 1'b0;
   logic                            reset = 1'b1;
   logic                            req_valid = 1'b0;
   logic                            req_ready;
   logic [7:0]                      req_data_byte = '0;
   logic                            rsp_valid;
   logic                            rsp_ready = 1'b0;
   logic [rfd_pkg::SLOT_W-1:0]      rsp_slot_number;
   logic [63:0]                     rsp_field_value;
   logic                            rsp_record_done;
   logic                            rsp_sequence_error;
   logic                            csr_valid = 1'b0;
   logic                            csr_ready;
   logic [rfd_pkg::CSR_INDEX_W-1:0] csr_index = '0;
   logic [rfd_pkg::CSR_DATA_W-1:0]  csr_data = '0;

   deframer_scoreboard_type sb = new();
   int unsigned             idle_pct = 27;
   int unsigned             bytes_sent = 0;
   int unsigned             cycle_count = 0;

   record_field_deframer_core u_top (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_data_byte      (req_data_byte),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_slot_number    (rsp_slot_number),
      .rsp_field_value    (rsp_field_value),
      .rsp_record_done    (rsp_record_done),
      .rsp_sequence_error (rsp_sequence_error),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_index          (csr_index),
      .csr_data           (csr_data)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("TEST FAILED");
         $finish;
      end
   end

   // result side: sample at the edge, then pick the next ready
   initial begin
      field_result_type got;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid && rsp_ready) begin
            got.slot = rsp_slot_number;
            got.value = rsp_field_value;
            got.done = rsp_record_done;
            got.err = rsp_sequence_error;
            sb.check_field(got);
         end
         rsp_ready <= ($urandom_range(99) >= idle_pct);
      end
   end

   task automatic send_byte(logic [7:0] b);
      if ($urandom_range(99) < idle_pct) begin
         req_valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < idle_pct);
      end
      req_valid <= 1'b1;
      req_data_byte <= b;
      do @(posedge clock); while (!req_ready);
      sb.accept_byte(b);
      bytes_sent++;
   endtask

   // sends the rest of the field for the current slot, from the byte already reached
   task automatic send_field(logic [63:0] v);
      int unsigned k;
      int unsigned w;
      k = sb.collected;
      w = sb.slot_bytes(sb.slot);
      do begin
         send_byte(v[8*k +: 8]);
         k++;
      end while (k < w);
   endtask

   task automatic settle();
      req_valid <= 1'b0;
      while (sb.pending_fields.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic csr_write(logic [rfd_pkg::CSR_INDEX_W-1:0] idx,
                            logic [rfd_pkg::CSR_DATA_W-1:0] d);
      settle();
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= d;
      do @(posedge clock); while (!csr_ready);
      sb.write_register(idx, d);
      csr_valid <= 1'b0;
   endtask

   function automatic logic [63:0] pick_value();
      int unsigned r;
      logic        last;
      r = $urandom_range(99);
      last = (sb.slot + 1 >= sb.slot_limit());
      if (last && sb.check_enable && r < 60) return sb.next_sequence;
      if (r < 68) return '0;
      if (r < 76) return '1;
      if (r < 84) return 64'($urandom_range(15));
      return {$urandom, $urandom};
   endfunction

   initial begin
      int unsigned                  start;
      int unsigned                  r;
      logic [rfd_pkg::COUNT_W-1:0]  count;
      logic [rfd_pkg::WIDTHS_W-1:0] widths;
      logic                         check;

      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // two-byte all-ones is not a drop marker
      send_field(64'hFFFF);
      csr_write(rfd_pkg::CSR_CHECK_ENABLE, 16'd1);
      csr_write(rfd_pkg::CSR_FIELD_WIDTHS, 16'({rfd_pkg::WIDTH_FLOAT, rfd_pkg::WIDTH_4B}));
      csr_write(rfd_pkg::CSR_FIELD_COUNT, 16'd2);
      send_field(rfd_pkg::DROP_MARKER);
      send_field(64'h8000_0000);
      send_field(sb.next_sequence);
      // width shrinks mid-field
      csr_write(rfd_pkg::CSR_FIELD_WIDTHS, 16'(rfd_pkg::WIDTH_8B));
      csr_write(rfd_pkg::CSR_FIELD_COUNT, 16'd1);
      send_byte(8'h11);
      send_byte(8'h22);
      send_byte(8'h33);
      csr_write(rfd_pkg::CSR_FIELD_WIDTHS, 16'(rfd_pkg::WIDTH_2B));
      send_byte(8'h44);
      // ignored index, saturated count, then count lowered mid-record
      csr_write(CSR_SPARE_INDEX, 16'hFFFF);
      csr_write(rfd_pkg::CSR_FIELD_COUNT, 16'd15);
      send_field(64'h00A5);
      csr_write(rfd_pkg::CSR_FIELD_COUNT, 16'd1);
      send_field(sb.next_sequence);
      csr_write(rfd_pkg::CSR_FIELD_COUNT, 16'd0);
      send_field(64'h5A5A);

      for (int unsigned phase = 0; phase < PHASE_COUNT; phase++) begin
         count = 4'($urandom_range(15));
         widths = 16'($urandom_range(16'hFFFF));
         check = 1'($urandom_range(1));
         case (phase)
            0: begin count = 4'd1; widths = 16'h0000; check = 1'b1; end
            1: begin count = 4'd8; widths = 16'hFFFF; check = 1'b1; end
            2: begin count = 4'd15; widths = 16'hAAAA; check = 1'b0; end
            3: begin count = 4'd0; widths = 16'h5555; end
            4: begin count = 4'd3; widths = 16'hAAAA; check = 1'b1; end
            default: ;
         endcase
         csr_write(rfd_pkg::CSR_FIELD_COUNT, 16'(count));
         csr_write(rfd_pkg::CSR_FIELD_WIDTHS, widths);
         csr_write(rfd_pkg::CSR_CHECK_ENABLE, 16'(check));
         idle_pct = (phase == 5) ? 0 : 27;
         start = bytes_sent;
         while (bytes_sent - start < PHASE_BYTES) begin
            r = $urandom_range(99);
            if (r < 6) begin
               repeat ($urandom_range(1, 5)) send_byte(8'($urandom));
            end else if (r < 16) begin
               send_field(rfd_pkg::DROP_MARKER);
            end else begin
               send_field(pick_value());
            end
         end
      end

      settle();
      repeat (10) @(posedge clock);
      if (sb.mismatches == 0 && sb.pending_fields.size() == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule

// ----- record_field_deframer_core.f -----
rtl/rfd_pkg.sv
rtl/record_field_deframer_core.sv
dv/record_field_deframer_core_tb.sv
